// ===== src/smf_pkg.sv =====
// smf_pkg: shared types of the sliding median filter
// no dependencies; used by smf_cell and sliding_median_filter
package smf_pkg;

	// per-cycle control that the top level drives into each window cell
	typedef struct packed {
		logic push;
		logic clr;
		logic cap;
	} smf_cell_ctrl_t;

endpackage

// ===== src/smf_in_if.sv =====
// smf_in_if: valid/ready channel carrying one input point per beat
// no dependencies
interface smf_in_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] x_in;
	logic signed [W-1:0] y_in;
	logic signed [W-1:0] z_in;
	logic                last_in;

	modport source (output valid, x_in, y_in, z_in, last_in, input ready);
	modport sink (input valid, x_in, y_in, z_in, last_in, output ready);
endinterface

// ===== src/smf_out_if.sv =====
// smf_out_if: valid/ready channel carrying one filtered point per beat
// no dependencies
interface smf_out_if #(
	parameter int W = 16
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] x_med;
	logic signed [W-1:0] y_out;
	logic signed [W-1:0] z_out;
	logic                last_out;

	modport source (output valid, x_med, y_out, z_out, last_out, input ready);
	modport sink (input valid, x_med, y_out, z_out, last_out, output ready);
endinterface

// ===== src/smf_cell.sv =====
// smf_cell: one tap of the x window; shifts from its neighbor or the input and ranks its
// own sample against the whole window, registering whether it holds the median
// depends on smf_pkg
module smf_cell
	import smf_pkg::*;
#(
	parameter int W   = 16,
	parameter int WIN = 5,
	parameter int IDX = 0,
	parameter int MID = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smf_cell_ctrl_t      ctrl,
	input  logic signed [W-1:0] din,
	input  logic signed [W-1:0] win [WIN],
	output logic signed [W-1:0] q,
	output logic                sel_s2,
	output logic signed [W-1:0] val_s2
);
	localparam int RW = $clog2(WIN);

	logic signed [W-1:0] x_q;
	logic [WIN-1:0]      lt;
	logic [RW-1:0]       rank;

	// ties broken by position so that the ranks form a permutation
	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			if (j == IDX) begin
				lt[j] = 1'b0;
			end else if (j < IDX) begin
				lt[j] = (win[j] < x_q) || (win[j] == x_q);
			end else begin
				lt[j] = win[j] < x_q;
			end
		end
		rank = RW'($countones(lt));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (ctrl.push) begin
			x_q <= ctrl.clr ? '0 : din;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			sel_s2 <= rank == RW'(MID);
			val_s2 <= x_q;
		end
	end

	assign q = x_q;
endmodule

// ===== src/sliding_median_filter.sv =====
// sliding_median_filter: zero-padded running median of x over 2*KERNEL_HALF+1 points,
// y and z delayed alongside; depends on smf_pkg, smf_in_if, smf_out_if, smf_cell
//
// One point is accepted per cycle unless a flush or output back-pressure holds the input.
// Each beat shifts the x window (a row of 2*KERNEL_HALF+1 cells) and a KERNEL_HALF+1 deep
// y/z delay line; the cells rank their samples in parallel and the median is picked in the
// output stage; a result passes the window, capture and output registers before
// out_pt.valid rises. The first KERNEL_HALF points of a stream give no result. A beat with
// last_in set is followed by KERNEL_HALF zero-padded flush pushes, with in_pt.ready low;
// the final result carries last_out, and the next stream's first push clears the window.
module sliding_median_filter
	import smf_pkg::*;
#(
	parameter int KERNEL_HALF = 2,
	parameter int SAMPLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	smf_in_if.sink    in_pt,
	smf_out_if.source out_pt
);
	localparam int W   = SAMPLE_BITS;
	localparam int WIN = 2 * KERNEL_HALF + 1;
	localparam int CW  = $clog2(KERNEL_HALF + 1);
	localparam logic [CW-1:0] KH = CW'(KERNEL_HALF);

	logic [CW-1:0]       flush_q;
	logic [CW-1:0]       fcnt_q;
	logic                clr_q;
	logic                vw_q;
	logic                lastw_q;
	logic                v2_q;
	logic                last_s2;
	logic signed [W-1:0] y_s2;
	logic signed [W-1:0] z_s2;
	logic                v3_q;
	logic                last_s3;
	logic signed [W-1:0] x_s3;
	logic signed [W-1:0] y_s3;
	logic signed [W-1:0] z_s3;
	logic signed [W-1:0] yd_q [KERNEL_HALF+1];
	logic signed [W-1:0] zd_q [KERNEL_HALF+1];

	logic signed [W-1:0] win [WIN];
	logic signed [W-1:0] val_s2 [WIN];
	logic [WIN-1:0]      sel_s2;
	logic signed [W-1:0] med;

	logic                ready_s3, ready_s2, push_ok, flushing;
	logic                in_beat, flush_push, push, cap, mv3;
	logic signed [W-1:0] x_new, y_new, z_new;
	logic [CW:0]         fsum;
	logic                em, last_new;
	smf_cell_ctrl_t      cctrl, hctrl;

	assign ready_s3   = !v3_q || out_pt.ready;
	assign ready_s2   = !v2_q || ready_s3;
	assign push_ok    = !vw_q || ready_s2;
	assign flushing   = flush_q != '0;
	assign in_pt.ready = !flushing && push_ok;
	assign in_beat    = in_pt.valid && in_pt.ready;
	assign flush_push = flushing && push_ok;
	assign push       = in_beat || flush_push;
	assign cap        = vw_q && ready_s2;
	assign mv3        = v2_q && ready_s3;

	assign x_new = flushing ? '0 : in_pt.x_in;
	assign y_new = flushing ? '0 : in_pt.y_in;
	assign z_new = flushing ? '0 : in_pt.z_in;

	// during flush the count already includes the last point
	assign fsum     = {1'b0, flush_q} + {1'b0, fcnt_q};
	assign em       = flushing ? (fsum > {1'b0, KH}) : (fcnt_q == KH);
	assign last_new = flushing && (flush_q == KH);

	assign cctrl = '{push: push, clr: clr_q, cap: cap};
	assign hctrl = '{push: push, clr: 1'b0, cap: cap};

	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == WIN - 1) begin : g_head
			smf_cell #(.W(W), .WIN(WIN), .IDX(i), .MID(KERNEL_HALF)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (hctrl),
				.din    (x_new),
				.win    (win),
				.q      (win[i]),
				.sel_s2 (sel_s2[i]),
				.val_s2 (val_s2[i])
			);
		end else begin : g_body
			smf_cell #(.W(W), .WIN(WIN), .IDX(i), .MID(KERNEL_HALF)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cctrl),
				.din    (win[i+1]),
				.win    (win),
				.q      (win[i]),
				.sel_s2 (sel_s2[i]),
				.val_s2 (val_s2[i])
			);
		end
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < WIN; i++) begin
			med = med | (val_s2[i] & {W{sel_s2[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= '0;
			fcnt_q  <= '0;
			clr_q   <= 1'b0;
			vw_q    <= 1'b0;
			lastw_q <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
		end else begin
			if (push) begin
				vw_q    <= em;
				lastw_q <= last_new;
			end else if (cap) begin
				vw_q <= 1'b0;
			end
			if (in_beat) begin
				clr_q <= 1'b0;
				if (fcnt_q != KH) begin
					fcnt_q <= fcnt_q + CW'(1);
				end
				if (in_pt.last_in) begin
					flush_q <= CW'(1);
				end
			end
			if (flush_push) begin
				if (flush_q == KH) begin
					flush_q <= '0;
					fcnt_q  <= '0;
					clr_q   <= 1'b1;
				end else begin
					flush_q <= flush_q + CW'(1);
				end
			end
			if (cap) begin
				v2_q <= 1'b1;
			end else if (mv3) begin
				v2_q <= 1'b0;
			end
			if (mv3) begin
				v3_q <= 1'b1;
			end else if (out_pt.ready) begin
				v3_q <= 1'b0;
			end
		end
	end

	// y/z delay line, oldest at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= KERNEL_HALF; i++) begin
				yd_q[i] <= '0;
				zd_q[i] <= '0;
			end
		end else if (push) begin
			for (int i = 0; i < KERNEL_HALF; i++) begin
				yd_q[i] <= clr_q ? '0 : yd_q[i+1];
				zd_q[i] <= clr_q ? '0 : zd_q[i+1];
			end
			yd_q[KERNEL_HALF] <= y_new;
			zd_q[KERNEL_HALF] <= z_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			last_s2 <= lastw_q;
			y_s2    <= yd_q[0];
			z_s2    <= zd_q[0];
		end
		if (mv3) begin
			last_s3 <= last_s2;
			x_s3    <= med;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
		end
	end

	assign out_pt.valid    = v3_q;
	assign out_pt.x_med    = x_s3;
	assign out_pt.y_out    = y_s3;
	assign out_pt.z_out    = z_s3;
	assign out_pt.last_out = last_s3;

	a_one_median: assert property (@(posedge clk) disable iff (!arst_n)
		v2_q |-> $onehot(sel_s2))
		else $error("median select not one-hot");

	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && in_pt.last_in |=> !in_pt.ready)
		else $error("input taken right after last beat");

	a_flush_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_push && (flush_q == KH) |=> clr_q && (fcnt_q == '0) && !flushing)
		else $error("stream end did not arm clear");

	a_window_held: assert property (@(posedge clk) disable iff (!arst_n)
		vw_q && !ready_s2 |=> vw_q && $stable(win[WIN-1]))
		else $error("window moved under pending result");
endmodule
